[hw/rtl/mieu_pkg.sv]
// Package for the integer execute unit: opcode and funct codes, shared types.
// No dependencies.
package mieu_pkg;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;

   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_JALR  = 6'h09;
   localparam logic [5:0] FN_BREAK = 6'h0D;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MTHI  = 6'h11;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MTLO  = 6'h13;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1A;
   localparam logic [5:0] FN_DIVU  = 6'h1B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLT   = 6'h2A;
   localparam logic [5:0] FN_SLTU  = 6'h2B;

   localparam logic [4:0] RI_BLTZ   = 5'h00;
   localparam logic [4:0] RI_BGEZ   = 5'h01;
   localparam logic [4:0] RI_BLTZAL = 5'h10;
   localparam logic [4:0] RI_BGEZAL = 5'h11;

   localparam logic [4:0] LINK_REG = 5'd31;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // Multi-cycle operations that the datapath runs for the controller.
   typedef enum logic [1:0] {
      MD_MUL  = 2'd0,
      MD_DIV  = 2'd1
   } md_kind_type;

   // Controller to datapath.
   typedef struct packed {
      logic        load;       // capture the incoming transaction
      logic        md_start;   // set up a multiply or divide
      logic        md_step;    // one iteration of the shared unit
      logic        md_finish;  // write HI/LO from the iteration registers
      logic        rsp_load;   // result register takes new value
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic        is_md;      // captured instruction needs the iterative unit
      logic        md_last;    // iteration count reached its end
   } status_type;

endpackage

[hw/rtl/mieu_if.sv]
// Valid/ready channel carrying one payload type.
// Depends on nothing; payload type is a parameter.
interface mieu_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mieu_ctrl.sv]
// Controller state machine of the integer execute unit.
// Depends on mieu_pkg.
module mieu_ctrl
   import mieu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECIDE = 4'b0010,
      ST_ITER   = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // Input is taken only while idle. The result register frees in the done
   // state when it is empty or being drained this cycle.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.load     = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_md) begin
               cmd.md_start = 1'b1;
               state_in     = ST_ITER;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ITER: begin
            cmd.md_step = 1'b1;
            if (status.md_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.md_finish = status.is_md;
               cmd.rsp_load  = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/mieu_dpath.sv]
// Datapath of the integer execute unit: decode, combinational ALU, radix-2
// shift-add multiplier / restoring divider, HI/LO and the result register.
// Depends on mieu_pkg.
module mieu_dpath
   import mieu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_instr_address,
   input  logic [31:0] req_rs_value,
   input  logic [31:0] req_rt_value,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [31:0] rsp_write_value,
   output logic [4:0]  rsp_dest_reg,
   output logic        rsp_write_enable,
   output logic        rsp_branch_taken,
   output logic [31:0] rsp_branch_target,
   output logic        rsp_not_handled
);

   logic [31:0] ins_ff, pc_ff, a_ff, b_ff;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;

   // Iteration registers: acc holds the high part / remainder, q the low part.
   logic [32:0] acc_ff, acc_in;
   logic [31:0] q_ff, q_in, m_ff, m_in;
   logic [5:0]  cnt_ff, cnt_in;
   md_kind_type kind_ff, kind_in;
   logic        sgn_ff, sgn_in, neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, dz_ff, dz_in;

   logic [31:0] val_ff, tgt_ff;
   logic [4:0]  dst_ff;
   logic        we_ff, tk_ff, bad_ff;

   logic [5:0]  op, fn;
   logic [4:0]  rt, rd, sa, sh;
   logic [31:0] immu, imms, pc4, link, btgt;
   logic [31:0] val, tgt;
   logic [4:0]  dst;
   logic        wr, taken, bad, bcond;
   logic        slt_s, slt_u;

   assign op   = ins_ff[31:26];
   assign rt   = ins_ff[20:16];
   assign rd   = ins_ff[15:11];
   assign sa   = ins_ff[10:6];
   assign fn   = ins_ff[5:0];
   assign immu = {16'd0, ins_ff[15:0]};
   assign imms = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign pc4  = pc_ff + 32'd4;
   assign link = pc_ff + 32'd8;
   assign btgt = pc4 + {imms[29:0], 2'b00};
   assign sh   = fn[2] ? a_ff[4:0] : sa;

   assign status.is_md = (op == OP_SPECIAL) &&
      (fn == FN_MULT || fn == FN_MULTU || fn == FN_DIV || fn == FN_DIVU);
   assign status.md_last = (cnt_ff == 6'd31);

   always_comb begin
      val   = '0;
      dst   = '0;
      tgt   = '0;
      wr    = 1'b0;
      taken = 1'b0;
      bad   = 1'b0;
      bcond = 1'b0;
      slt_s = $signed(a_ff) < $signed(op == OP_SPECIAL ? b_ff : imms);
      slt_u = a_ff < (op == OP_SPECIAL ? b_ff : imms);
      case (op)
         OP_SPECIAL: begin
            dst = rd;
            wr  = 1'b1;
            case (fn)
               FN_SLL, FN_SLLV: val = b_ff << sh;
               FN_SRL, FN_SRLV: val = b_ff >> sh;
               FN_SRA, FN_SRAV: val = 32'($signed(b_ff) >>> sh);
               FN_JR: begin
                  wr = 1'b0; dst = '0; taken = 1'b1; tgt = a_ff;
               end
               FN_JALR: begin
                  taken = 1'b1; tgt = a_ff; val = link;
               end
               FN_BREAK, FN_MTHI, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
                  wr = 1'b0; dst = '0;
               end
               FN_MFHI: val = hi_ff;
               FN_MFLO: val = lo_ff;
               FN_ADD, FN_ADDU: val = a_ff + b_ff;
               FN_SUB, FN_SUBU: val = a_ff - b_ff;
               FN_AND: val = a_ff & b_ff;
               FN_OR:  val = a_ff | b_ff;
               FN_XOR: val = a_ff ^ b_ff;
               FN_NOR: val = ~(a_ff | b_ff);
               FN_SLT:  val = {31'd0, slt_s};
               FN_SLTU: val = {31'd0, slt_u};
               default: bad = 1'b1;
            endcase
         end
         OP_REGIMM: begin
            case (rt)
               RI_BLTZ: bcond = a_ff[31];
               RI_BGEZ: bcond = !a_ff[31];
               RI_BLTZAL: begin
                  bcond = a_ff[31]; val = link; dst = LINK_REG; wr = 1'b1;
               end
               RI_BGEZAL: begin
                  bcond = !a_ff[31]; val = link; dst = LINK_REG; wr = 1'b1;
               end
               default: bad = 1'b1;
            endcase
            taken = bcond;
            tgt   = bcond ? btgt : '0;
         end
         OP_J, OP_JAL: begin
            taken = 1'b1;
            tgt   = {pc4[31:28], ins_ff[25:0], 2'b00};
            if (op == OP_JAL) begin
               val = link; dst = LINK_REG; wr = 1'b1;
            end
         end
         OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
            case (op)
               OP_BEQ:  bcond = (a_ff == b_ff);
               OP_BNE:  bcond = (a_ff != b_ff);
               OP_BLEZ: bcond = (a_ff == '0) || a_ff[31];
               default: bcond = (a_ff != '0) && !a_ff[31];
            endcase
            taken = bcond;
            tgt   = bcond ? btgt : '0;
         end
         OP_ADDI, OP_ADDIU: begin val = a_ff + imms; dst = rt; wr = 1'b1; end
         OP_SLTI:  begin val = {31'd0, slt_s}; dst = rt; wr = 1'b1; end
         OP_SLTIU: begin val = {31'd0, slt_u}; dst = rt; wr = 1'b1; end
         OP_ANDI:  begin val = a_ff & immu; dst = rt; wr = 1'b1; end
         OP_ORI:   begin val = a_ff | immu; dst = rt; wr = 1'b1; end
         OP_XORI:  begin val = a_ff ^ immu; dst = rt; wr = 1'b1; end
         OP_LUI:   begin val = {ins_ff[15:0], 16'd0}; dst = rt; wr = 1'b1; end
         default: bad = 1'b1;
      endcase
      if (bad) begin
         val = '0; dst = '0; wr = 1'b0; taken = 1'b0; tgt = '0;
      end
   end

   // Iterative multiply / divide and HI/LO.
   logic [31:0] mag_a, mag_b, q_fix, r_fix;
   logic [32:0] sum, trial;
   always_comb begin
      acc_in   = acc_ff;
      q_in     = q_ff;
      m_in     = m_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      sgn_in   = sgn_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      dz_in    = dz_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mag_a    = (fn == FN_DIV && a_ff[31]) ? 32'd0 - a_ff : a_ff;
      mag_b    = (fn == FN_DIV && b_ff[31]) ? 32'd0 - b_ff : b_ff;
      sum      = {1'b0, acc_ff[31:0]} + (q_ff[0] ? {1'b0, m_ff} : 33'd0);
      trial    = {acc_ff[31:0], q_ff[31]} - {1'b0, m_ff};
      q_fix    = neg_q_ff ? 32'd0 - q_ff : q_ff;
      r_fix    = neg_r_ff ? 32'd0 - acc_ff[31:0] : acc_ff[31:0];
      if (cmd.load && status.is_md) begin
         // Nothing; setup happens in md_start with the captured operands.
      end
      if (cmd.md_start) begin
         cnt_in = '0;
         acc_in = '0;
         if (fn == FN_MULT || fn == FN_MULTU) begin
            // Unsigned product, then signed fixup on the high word at the end.
            kind_in = MD_MUL;
            sgn_in  = (fn == FN_MULT);
            q_in    = b_ff;
            m_in    = a_ff;
         end else begin
            kind_in  = MD_DIV;
            q_in     = mag_a;
            m_in     = mag_b;
            dz_in    = (b_ff == '0);
            neg_q_in = (fn == FN_DIV) && (a_ff[31] != b_ff[31]);
            neg_r_in = (fn == FN_DIV) && a_ff[31];
         end
      end
      if (cmd.md_step) begin
         cnt_in = cnt_ff + 6'd1;
         if (kind_ff == MD_MUL) begin
            acc_in = {1'b0, sum[32:1]};
            q_in   = {sum[0], q_ff[31:1]};
         end else if (!trial[32]) begin
            acc_in = {1'b0, trial[31:0]};
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            acc_in = {1'b0, acc_ff[30:0], q_ff[31]};
            q_in   = {q_ff[30:0], 1'b0};
         end
      end
      if (cmd.md_finish) begin
         if (kind_ff == MD_MUL) begin
            lo_in = q_ff;
            hi_in = acc_ff[31:0]
               - ((sgn_ff && a_ff[31]) ? b_ff : 32'd0)
               - ((sgn_ff && b_ff[31]) ? a_ff : 32'd0);
         end else if (dz_ff) begin
            hi_in = a_ff;
            lo_in = (fn == FN_DIV && a_ff[31]) ? 32'd1 : ALL_ONES;
         end else begin
            lo_in = q_fix;
            hi_in = r_fix;
         end
      end
      if (cmd.rsp_load && !bad && op == OP_SPECIAL) begin
         if (fn == FN_MTHI) hi_in = a_ff;
         if (fn == FN_MTLO) lo_in = a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ins_ff <= req_instruction;
         pc_ff  <= req_instr_address;
         a_ff   <= req_rs_value;
         b_ff   <= req_rt_value;
      end
      acc_ff   <= acc_in;
      q_ff     <= q_in;
      m_ff     <= m_in;
      cnt_ff   <= cnt_in;
      kind_ff  <= kind_in;
      sgn_ff   <= sgn_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      dz_ff    <= dz_in;
      if (cmd.rsp_load) begin
         val_ff <= val;
         dst_ff <= dst;
         we_ff  <= wr && (dst != '0);
         tk_ff  <= taken;
         tgt_ff <= tgt;
         bad_ff <= bad;
      end
   end

   assign rsp_write_value   = val_ff;
   assign rsp_dest_reg      = dst_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_branch_taken  = tk_ff;
   assign rsp_branch_target = tgt_ff;
   assign rsp_not_handled   = bad_ff;

endmodule

[hw/rtl/mips_integer_execute_unit_top.sv]
// Integer execute stage of a MIPS I core. One transaction carries an
// instruction, its address and both source register values, and returns one
// result transaction with the write-back value, destination, write enable,
// branch decision and target, and a flag for instructions this unit does not
// execute. ALU, shift, branch, jump and HI/LO move instructions pass through
// the decide and done states from acceptance to the result register, and the
// next transaction can be accepted in the cycle after that. MULT, MULTU, DIV
// and DIVU run through one shared radix-2 shift-add/restoring-subtract unit,
// one bit per cycle, and pass through the decide, iterate and done states from
// acceptance to the result register. The next transaction is accepted once the
// result register has been loaded, so the result can wait downstream while new
// work starts; if the previous result is still waiting when a new one is ready,
// the unit holds until it is taken. Divide by zero and the most negative number
// divided by minus one give defined HI/LO values; overflow never traps.
// Depends on mieu_pkg, mieu_ctrl and mieu_dpath.
module mips_integer_execute_unit_top
   import mieu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_instr_address,
   input  logic [31:0] req_rs_value,
   input  logic [31:0] req_rt_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_write_value,
   output logic [4:0]  rsp_dest_reg,
   output logic        rsp_write_enable,
   output logic        rsp_branch_taken,
   output logic [31:0] rsp_branch_target,
   output logic        rsp_not_handled
);

   cmd_type    cmd;
   status_type status;

   // The controller sequences each transaction; the datapath does the work.
   mieu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mieu_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_instruction   (req_instruction),
      .req_instr_address (req_instr_address),
      .req_rs_value      (req_rs_value),
      .req_rt_value      (req_rt_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_write_value   (rsp_write_value),
      .rsp_dest_reg      (rsp_dest_reg),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_branch_target (rsp_branch_target),
      .rsp_not_handled   (rsp_not_handled)
   );

endmodule

[verif/tb.sv]
// Self-checking testbench for mips_integer_execute_unit_top.
// Depends on mieu_pkg and mieu_if from the RTL; a built-in predictor checks every result.
module tb;
   import mieu_pkg::*;

   // Codes the unit must flag as not handled.
   localparam logic [5:0] OP_LW       = 6'h23;
   localparam logic [5:0] FN_UNUSED   = 6'h01;
   localparam logic [4:0] RI_UNUSED   = 5'h02;
   localparam int         WATCHDOG_LIMIT = 20000;
   localparam int         RANDOM_ITEMS   = 800;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] instr_address;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
   } exec_req_type;

   typedef struct packed {
      logic [31:0] write_value;
      logic [4:0]  dest_reg;
      logic        write_enable;
      logic        branch_taken;
      logic [31:0] branch_target;
      logic        not_handled;
   } exec_rsp_type;

   logic clock;
   logic reset;

   mieu_if #(.payload_type(exec_req_type)) req_ch ();
   mieu_if #(.payload_type(exec_rsp_type)) rsp_ch ();

   mips_integer_execute_unit_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_instruction   (req_ch.data.instruction),
      .req_instr_address (req_ch.data.instr_address),
      .req_rs_value      (req_ch.data.rs_value),
      .req_rt_value      (req_ch.data.rt_value),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_write_value   (rsp_ch.data.write_value),
      .rsp_dest_reg      (rsp_ch.data.dest_reg),
      .rsp_write_enable  (rsp_ch.data.write_enable),
      .rsp_branch_taken  (rsp_ch.data.branch_taken),
      .rsp_branch_target (rsp_ch.data.branch_target),
      .rsp_not_handled   (rsp_ch.data.not_handled)
   );

   // Instructions waiting to be offered, and results the unit still owes us.
   exec_req_type pending_instrs[$];
   exec_rsp_type expected_results[$];

   // Shadow copy of the HI/LO registers, updated as instructions are accepted.
   logic [31:0] shadow_hi;
   logic [31:0] shadow_lo;

   int accepted_count;
   int checked_count;
   int mismatch_count;
   int idle_cycles;
   int drain_point;
   bit calm_mode;

   always #1 clock = ~clock;

   // Gap lengths: mostly none or short, now and then long. In calm mode
   // there are no gaps at all, so back-to-back streams are exercised too.
   function automatic int pick_gap(bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Predicts the result of one instruction and advances the HI/LO shadow.
   function automatic exec_rsp_type execute_instr(exec_req_type r);
      exec_rsp_type res;
      logic [5:0]  op, fn;
      logic [4:0]  rt, rd, sa;
      logic [31:0] a, b, imms, immu, pc4, link, btgt, ma, mb, q, rem;
      logic [63:0] prod;
      logic        taken, wr, bad;
      op = r.instruction[31:26];
      rt = r.instruction[20:16];
      rd = r.instruction[15:11];
      sa = r.instruction[10:6];
      fn = r.instruction[5:0];
      a = r.rs_value;
      b = r.rt_value;
      immu = {16'h0, r.instruction[15:0]};
      imms = {{16{r.instruction[15]}}, r.instruction[15:0]};
      pc4 = r.instr_address + 32'd4;
      link = r.instr_address + 32'd8;
      btgt = pc4 + (imms << 2);
      res = '0;
      taken = 1'b0;
      wr = 1'b0;
      bad = 1'b0;
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_SLL:  begin res.write_value = b << sa; wr = 1; end
               FN_SRL:  begin res.write_value = b >> sa; wr = 1; end
               FN_SRA:  begin res.write_value = $signed(b) >>> sa; wr = 1; end
               FN_SLLV: begin res.write_value = b << a[4:0]; wr = 1; end
               FN_SRLV: begin res.write_value = b >> a[4:0]; wr = 1; end
               FN_SRAV: begin res.write_value = $signed(b) >>> a[4:0]; wr = 1; end
               FN_JR: begin
                  taken = 1;
                  res.branch_target = a;
               end
               FN_JALR: begin
                  taken = 1;
                  res.branch_target = a;
                  res.write_value = link;
                  wr = 1;
               end
               FN_BREAK: ;
               FN_MFHI: begin res.write_value = shadow_hi; wr = 1; end
               FN_MFLO: begin res.write_value = shadow_lo; wr = 1; end
               FN_MTHI: shadow_hi = a;
               FN_MTLO: shadow_lo = a;
               FN_MULT: begin
                  prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                  {shadow_hi, shadow_lo} = prod;
               end
               FN_MULTU: begin
                  prod = {32'h0, a} * {32'h0, b};
                  {shadow_hi, shadow_lo} = prod;
               end
               FN_DIV: begin
                  if (b == 32'h0) begin
                     shadow_lo = a[31] ? 32'd1 : ALL_ONES;
                     shadow_hi = a;
                  end else begin
                     // Work on magnitudes; the most negative dividend wraps
                     // to itself, which gives the defined result for -1.
                     ma = a[31] ? -a : a;
                     mb = b[31] ? -b : b;
                     q = ma / mb;
                     rem = ma % mb;
                     shadow_lo = (a[31] != b[31]) ? -q : q;
                     shadow_hi = a[31] ? -rem : rem;
                  end
               end
               FN_DIVU: begin
                  if (b == 32'h0) begin
                     shadow_lo = ALL_ONES;
                     shadow_hi = a;
                  end else begin
                     shadow_lo = a / b;
                     shadow_hi = a % b;
                  end
               end
               FN_ADD, FN_ADDU: begin res.write_value = a + b; wr = 1; end
               FN_SUB, FN_SUBU: begin res.write_value = a - b; wr = 1; end
               FN_AND: begin res.write_value = a & b; wr = 1; end
               FN_OR:  begin res.write_value = a | b; wr = 1; end
               FN_XOR: begin res.write_value = a ^ b; wr = 1; end
               FN_NOR: begin res.write_value = ~(a | b); wr = 1; end
               FN_SLT: begin res.write_value = {31'h0, $signed(a) < $signed(b)}; wr = 1; end
               FN_SLTU: begin res.write_value = {31'h0, a < b}; wr = 1; end
               default: bad = 1;
            endcase
            if (wr) res.dest_reg = rd;
         end
         OP_REGIMM: begin
            case (rt)
               RI_BLTZ: taken = a[31];
               RI_BGEZ: taken = !a[31];
               RI_BLTZAL, RI_BGEZAL: begin
                  // The link is written whether or not the branch is taken.
                  taken = (rt == RI_BLTZAL) ? a[31] : !a[31];
                  res.write_value = link;
                  res.dest_reg = LINK_REG;
                  wr = 1;
               end
               default: bad = 1;
            endcase
            if (taken) res.branch_target = btgt;
         end
         OP_J, OP_JAL: begin
            taken = 1;
            res.branch_target = {pc4[31:28], r.instruction[25:0], 2'b00};
            if (op == OP_JAL) begin
               res.write_value = link;
               res.dest_reg = LINK_REG;
               wr = 1;
            end
         end
         OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
            case (op)
               OP_BEQ:  taken = (a == b);
               OP_BNE:  taken = (a != b);
               OP_BLEZ: taken = (a == 0) || a[31];
               default: taken = (a != 0) && !a[31];
            endcase
            if (taken) res.branch_target = btgt;
         end
         OP_ADDI, OP_ADDIU: begin res.write_value = a + imms; wr = 1; end
         OP_SLTI:  begin res.write_value = {31'h0, $signed(a) < $signed(imms)}; wr = 1; end
         OP_SLTIU: begin res.write_value = {31'h0, a < imms}; wr = 1; end
         OP_ANDI:  begin res.write_value = a & immu; wr = 1; end
         OP_ORI:   begin res.write_value = a | immu; wr = 1; end
         OP_XORI:  begin res.write_value = a ^ immu; wr = 1; end
         OP_LUI:   begin res.write_value = immu << 16; wr = 1; end
         default: bad = 1;
      endcase
      if (op >= OP_ADDI && op <= OP_LUI) res.dest_reg = rt;
      if (bad) res = '0;
      res.write_enable = wr && !bad && (res.dest_reg != 5'd0);
      res.branch_taken = taken && !bad;
      res.not_handled = bad;
      return res;
   endfunction

   function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rd, logic [4:0] sa);
      return {OP_SPECIAL, 5'($urandom), 5'($urandom), rd, sa, fn};
   endfunction

   function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rt, logic [15:0] imm);
      return {op, 5'($urandom), rt, imm};
   endfunction

   // Operand values that lean toward the interesting corners.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return ALL_ONES;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 40);
         5: return -$urandom_range(1, 40);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_valid_word();
      logic [5:0] fn_list[27];
      logic [5:0] op;
      logic [4:0] ri;
      fn_list = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
                  FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU,
                  FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
                  FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
      op = 6'($urandom_range(0, 15));
      if (op == OP_SPECIAL)
         return r_word(fn_list[$urandom_range(0, 26)], 5'($urandom), 5'($urandom));
      if (op == OP_REGIMM) begin
         ri = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 3'b000, 1'($urandom)};
         return {OP_REGIMM, 5'($urandom), ri, 16'($urandom)};
      end
      return {op, 26'($urandom)};
   endfunction

   task automatic add_instr(logic [31:0] word, logic [31:0] a, logic [31:0] b);
      exec_req_type r;
      r.instruction = word;
      r.instr_address = $urandom;
      r.rs_value = a;
      r.rt_value = b;
      pending_instrs.push_back(r);
   endtask

   // Driver: offers pending instructions, predicting each one as it is
   // accepted so the HI/LO shadow advances in acceptance order. The valid
   // line gets exactly one nonblocking assignment per edge.
   int gap_left;
   always @(posedge clock) begin
      bit offering;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else begin
         offering = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(execute_instr(req_ch.data));
            accepted_count++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_instrs.size() != 0 &&
                         !(accepted_count == drain_point && expected_results.size() != 0)) begin
               // At the drain point the sender holds off until the unit has
               // delivered everything it owes.
               req_ch.data <= pending_instrs.pop_front();
               offering = 1'b1;
               if (accepted_count % 100 == 0) calm_mode = $urandom_range(0, 3) == 0;
               gap_left = pick_gap(calm_mode);
            end
         end
         req_ch.valid <= offering;
      end
   end

   // Monitor: takes results with random back-pressure and checks each one
   // against the oldest prediction.
   int stall_left;
   always @(posedge clock) begin
      exec_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            checked_count++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transaction: %p", rsp_ch.data);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d mismatch: expected %p, actual %p",
                              checked_count, want, rsp_ch.data);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_left = pick_gap(calm_mode);
            rsp_ch.ready <= (stall_left == 0);
         end
      end
   end

   // Watchdog: a run that stops moving transactions is a failure.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int total;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      accepted_count = 0;
      checked_count = 0;
      mismatch_count = 0;
      idle_cycles = 0;
      calm_mode = 1'b0;
      shadow_hi = '0;
      shadow_lo = '0;

      // Directed part: reset values of HI/LO, divide corner cases, link
      // branches taken and not taken, jumps, BREAK and undecodable words.
      add_instr(r_word(FN_MFHI, 5'd1, 5'd0), 32'h0, 32'h0);
      add_instr(r_word(FN_MFLO, 5'd2, 5'd0), 32'h0, 32'h0);
      add_instr(r_word(FN_DIV, 5'd0, 5'd0), 32'h8000_0000, ALL_ONES);
      add_instr(r_word(FN_MFLO, 5'd3, 5'd0), 32'h0, 32'h0);
      add_instr(r_word(FN_DIV, 5'd0, 5'd0), 32'hFFFF_FFF9, 32'h0);
      add_instr(r_word(FN_MFHI, 5'd4, 5'd0), 32'h0, 32'h0);
      add_instr(r_word(FN_DIV, 5'd0, 5'd0), 32'h0000_0007, 32'h0);
      add_instr(r_word(FN_MFLO, 5'd5, 5'd0), 32'h0, 32'h0);
      add_instr(r_word(FN_DIVU, 5'd0, 5'd0), ALL_ONES, 32'h0);
      add_instr(r_word(FN_DIV, 5'd0, 5'd0), 32'hFFFF_FFF9, 32'h2);
      add_instr(r_word(FN_MULT, 5'd0, 5'd0), 32'h8000_0000, 32'h8000_0000);
      add_instr(r_word(FN_MULTU, 5'd0, 5'd0), ALL_ONES, ALL_ONES);
      add_instr(r_word(FN_MTHI, 5'd0, 5'd0), 32'h1234_5678, 32'h0);
      add_instr(r_word(FN_MTLO, 5'd0, 5'd0), ALL_ONES, 32'h0);
      add_instr(r_word(FN_SRAV, 5'd6, 5'd0), 32'hFFFF_FFE3, 32'h8000_0000);
      add_instr(r_word(FN_SRA, 5'd7, 5'd31), 32'h0, 32'h8000_0000);
      add_instr(r_word(FN_JALR, 5'd0, 5'd0), ALL_ONES, 32'h0);
      add_instr({OP_REGIMM, 5'd3, RI_BLTZAL, 16'h8000}, 32'h0, 32'h0);
      add_instr({OP_REGIMM, 5'd3, RI_BGEZAL, 16'h7FFF}, 32'h0, 32'h0);
      add_instr({OP_JAL, 26'h3FF_FFFF}, 32'h0, 32'h0);
      add_instr(r_word(FN_BREAK, 5'd0, 5'd0), 32'h0, 32'h0);
      add_instr({OP_LW, 26'h0}, 32'h1, 32'h2);
      add_instr(r_word(FN_UNUSED, 5'd9, 5'd0), 32'h1, 32'h2);
      add_instr({OP_REGIMM, 5'd1, RI_UNUSED, 16'h0}, 32'h8000_0000, 32'h0);
      add_instr(i_word(OP_SLTIU, 5'd8, 16'hFFFF), 32'h7FFF_FFFF, 32'h0);

      // Random part: mostly decodable instructions with skewed operands,
      // the rest raw words. Equal operands now and then for BEQ/BNE.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         logic [31:0] a;
         logic [31:0] b;
         a = pick_operand();
         b = ($urandom_range(0, 4) == 0) ? a : pick_operand();
         if ($urandom_range(0, 9) < 8)
            add_instr(pick_valid_word(), a, b);
         else
            add_instr($urandom, a, b);
      end
      total = pending_instrs.size();
      drain_point = total / 2;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == total && expected_results.size() == 0);
      repeat (60) @(posedge clock);
      $display("checked %0d result transactions from %0d instructions covering ALU,",
               checked_count, accepted_count);
      $display("shift, branch, jump, HI/LO and divide corner cases; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
